// File: rtl/core/tpltc_pkg.sv
// ----------------------------------------------------------------------------
// tpltc_pkg: shared types and constants for the touch pad tap counter
// Register indexes, register reset values and the tap count type.
// ----------------------------------------------------------------------------
`default_nettype none

package tpltc_pkg;

    // width of each configuration register
    localparam int CFG_W = 16;

    // configuration register indexes
    localparam logic CFG_IDX_COOLDOWN   = 1'b0;
    localparam logic CFG_IDX_TAP_WINDOW = 1'b1;

    // register values after reset
    localparam logic [CFG_W-1:0] COOLDOWN_RST   = 16'd250;
    localparam logic [CFG_W-1:0] TAP_WINDOW_RST = 16'd500;

    // tap count, saturating at three or more
    typedef logic [1:0] t_tap_cnt;
    localparam t_tap_cnt TAP_NONE = 2'd0;
    localparam t_tap_cnt TAP_MAX  = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/touch_pad_lockout_tap_counter.sv
// ----------------------------------------------------------------------------
// touch_pad_lockout_tap_counter: multi-tap detector with per-pad lockout
// One polling pass in, one event word out; debounces reset and item pads and
// turns mode pad taps into a 1/2/3+ selection after a quiet window.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload (low bit first)
//  s_axis    in   tvalid / tready    now_ms, mode_touch, reset_touch, pad_touch
//  m_axis    out  tvalid / tready    mode_chosen, reset_event, pad_events
//  cfg       in   we (no wait)       addr 0 cooldown_ms, addr 1 tap_window_ms
//
//  One pass per clock while the output drains: a word is held in the input
//  register, then the lockout compares and tap counter update pad state and
//  load the result register, which drives the output.
//  Synchronous active-low reset clears all stored times and the tap count,
//  and sets both configuration registers to 250 ms and 500 ms.
//  A stalled output holds its word; the input register keeps taking words as
//  long as it can drain into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_pad_lockout_tap_counter
    import tpltc_pkg::*;
#(
    parameter int NUM_PADS  = 5,
    parameter int TIME_BITS = 32,
    localparam int IN_BITS  = TIME_BITS + 2 + NUM_PADS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 3 + NUM_PADS,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // slave side
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // now_ms, mode_touch, reset_touch, pad_touch, zero fill
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    // master side
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // mode_chosen[1:0], reset_event, pad_events, zero fill
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int MODE_BIT  = TIME_BITS;
    localparam int RESET_BIT = TIME_BITS + 1;
    localparam int PAD_LSB   = TIME_BITS + 2;

    // configuration registers
    logic [CFG_W-1:0]     r_cooldown;
    logic [CFG_W-1:0]     r_window;

    // input register
    logic                 r_stg_valid;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_mode;
    logic                 r_reset;
    logic [NUM_PADS-1:0]  r_pads;

    // result register
    logic                 r_out_valid;
    logic [OUT_BITS-1:0]  r_out_data;

    logic                 in_take;
    logic                 advance;
    t_tap_cnt             chosen;
    logic                 reset_ev;
    logic [NUM_PADS-1:0]  pad_ev;
    logic [TIME_BITS-1:0] reset_last;
    logic [TIME_BITS-1:0] pad_last [NUM_PADS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooldown <= COOLDOWN_RST;
            r_window   <= TAP_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IDX_COOLDOWN:   r_cooldown <= i_cfg_wdata;
                CFG_IDX_TAP_WINDOW: r_window   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance the staged pass whenever the result register is free or draining
    assign advance         = r_stg_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_stg_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (in_take) begin
            r_stg_valid <= 1'b1;
        end else if (advance) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= i_s_axis_tdata[TIME_BITS-1:0];
            r_mode  <= i_s_axis_tdata[MODE_BIT];
            r_reset <= i_s_axis_tdata[RESET_BIT];
            r_pads  <= i_s_axis_tdata[PAD_LSB +: NUM_PADS];
        end
    end

    tpltc_tap #(
        .TIME_BITS (TIME_BITS)
    ) u_tap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_now      (r_now),
        .i_mode     (r_mode),
        .i_cooldown (r_cooldown),
        .i_window   (r_window),
        .o_chosen   (chosen)
    );

    tpltc_lockout #(
        .TIME_BITS (TIME_BITS)
    ) u_reset_lock (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_now     (r_now),
        .i_touch   (r_reset),
        .i_limit   (r_cooldown),
        .o_event   (reset_ev),
        .o_last    (reset_last)
    );

    // one lockout per item pad
    for (genvar g = 0; g < NUM_PADS; g++) begin : g_pad
        tpltc_lockout #(
            .TIME_BITS (TIME_BITS)
        ) u_pad_lock (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_now     (r_now),
            .i_touch   (r_pads[g]),
            .i_limit   (r_cooldown),
            .o_event   (pad_ev[g]),
            .o_last    (pad_last[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {pad_ev, reset_ev, chosen};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

    // a staged pass with a free result register always lands next cycle
    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_valid && (!r_out_valid || i_m_axis_tready)) |=> r_out_valid)
        else $error("staged pass did not reach the result register");

    // both registers full and stalled: no new word may enter
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted with both stages full");

    // an event on item pad 0 always moves that pad's stored time to now
    a_pad_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && pad_ev[0]) |=> (pad_last[0] == $past(r_now)))
        else $error("pad lockout time not updated on event");

    // a reset event always moves the reset pad's stored time to now
    a_reset_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && reset_ev) |=> (reset_last == $past(r_now)))
        else $error("reset lockout time not updated on event");

endmodule

`default_nettype wire

// File: rtl/core/tpltc_lockout.sv
// ----------------------------------------------------------------------------
// tpltc_lockout: per-pad touch lockout
// Holds the time of the last accepted touch and accepts a new one only when
// strictly more than the limit has passed, modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module tpltc_lockout
    import tpltc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic                 i_touch,
    input  wire logic [CFG_W-1:0]     i_limit,
    output logic                      o_event,
    output logic [TIME_BITS-1:0]      o_last
);

    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] n_last;
    logic [TIME_BITS-1:0] elapsed;

    assign elapsed = i_now - r_last;
    assign o_event = i_touch && (elapsed > TIME_BITS'(i_limit));
    assign n_last  = o_event ? i_now : r_last;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_advance) begin
            r_last <= n_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tpltc_tap.sv
// ----------------------------------------------------------------------------
// tpltc_tap: mode pad tap counter
// Counts accepted mode taps up to three and reports the count once the tap
// window has passed with no new tap.
// ----------------------------------------------------------------------------
`default_nettype none

module tpltc_tap
    import tpltc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic                 i_mode,
    input  wire logic [CFG_W-1:0]     i_cooldown,
    input  wire logic [CFG_W-1:0]     i_window,
    output t_tap_cnt                  o_chosen
);

    logic                 tap_ok;
    logic [TIME_BITS-1:0] last_tap;
    logic [TIME_BITS-1:0] quiet;
    logic                 report;
    t_tap_cnt             r_count;
    t_tap_cnt             n_count;
    t_tap_cnt             count_inc;

    tpltc_lockout #(
        .TIME_BITS (TIME_BITS)
    ) u_mode_lock (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (i_advance),
        .i_now     (i_now),
        .i_touch   (i_mode),
        .i_limit   (i_cooldown),
        .o_event   (tap_ok),
        .o_last    (last_tap)
    );

    // a tap taken in this pass blocks the report through !tap_ok, so it never reports here
    assign quiet     = i_now - last_tap;
    assign count_inc = (tap_ok && r_count != TAP_MAX) ? r_count + 2'd1 : r_count;
    assign report    = (count_inc != TAP_NONE) && !tap_ok
                       && (quiet > TIME_BITS'(i_window));
    assign o_chosen  = report ? count_inc : TAP_NONE;
    assign n_count   = report ? TAP_NONE : count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= TAP_NONE;
        end else if (i_advance) begin
            r_count <= n_count;
        end
    end

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_chosen != TAP_NONE) |=> (r_count == TAP_NONE))
        else $error("tap count not cleared after report");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == TAP_MAX) |=> (r_count == TAP_MAX || r_count == TAP_NONE))
        else $error("tap count left saturation other than by report");

endmodule

`default_nettype wire
